[src/modbus_slave_register_responder_core_defines.svh]
// assertion macros shared by the checker of the modbus responder core
`ifndef MODBUS_SLAVE_REGISTER_RESPONDER_CORE_DEFINES_SVH
`define MODBUS_SLAVE_REGISTER_RESPONDER_CORE_DEFINES_SVH

// same-cycle implication, off while reset is high
`define MSRR_ASSERT_IMPL(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("msrr assertion failed");

// next-cycle implication, off while reset is high
`define MSRR_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("msrr assertion failed");

// next-cycle implication that also holds across reset
`define MSRR_ASSERT_RESET(label, pre, post) \
   label: assert property (@(posedge clock) (pre) |=> (post)) \
      else $error("msrr reset assertion failed");

`endif

[src/msrr_pkg.sv]
// shared types, constants and crc function of the modbus responder core
package msrr_pkg;

   localparam int NUM_REGS_DEFAULT = 5;
   localparam int QUEUE_DEPTH      = 2;
   localparam int HDR_BYTES        = 6;

   localparam logic [7:0]  SLAVE_ADDR_RESET = 8'h01;
   localparam logic [7:0]  FN_READ          = 8'h03;
   localparam logic [7:0]  FN_WRITE         = 8'h06;
   localparam logic [7:0]  FN_EXC_FLAG      = 8'h80;
   localparam logic [7:0]  EXC_ILLEGAL_FN   = 8'h01;
   localparam logic [7:0]  EXC_ILLEGAL_ADDR = 8'h02;
   localparam logic [7:0]  FLAG_READ_BYTES  = 8'h02;
   localparam logic [7:0]  MAX_READ         = 8'h05;
   localparam logic [7:0]  MIN_FRAME_LEN    = 8'd4;
   localparam logic [7:0]  RW_FRAME_LEN     = 8'd8;
   localparam logic [7:0]  COUNT_MAX        = 8'hFF;
   localparam logic [15:0] CRC_INIT         = 16'hFFFF;
   localparam logic [15:0] CRC_POLY         = 16'hA001;

   // reply lengths in beats, crc included
   localparam logic [3:0] EXC_REPLY_LEN   = 4'd5;
   localparam logic [3:0] READ_BASE_LEN   = 4'd5;
   localparam logic [3:0] FLAG_REPLY_LEN  = 4'd7;
   localparam logic [3:0] WRITE_REPLY_LEN = 4'd8;
   localparam logic [3:0] CRC_BYTES       = 4'd2;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_end;
   } msrr_req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_last;
      logic       buzzer_on;
   } msrr_rsp_type;

   typedef enum logic [2:0] {
      JOB_EXC_FN,
      JOB_EXC_ADDR,
      JOB_READ,
      JOB_READ_FLAG,
      JOB_WRITE_REG,
      JOB_WRITE_FLAG
   } msrr_job_kind_type;

   // hdr[0] address, hdr[1] function, hdr[2..3] start, hdr[4..5] quantity or value
   typedef struct packed {
      msrr_job_kind_type           kind;
      logic [HDR_BYTES-1:0][7:0]   hdr;
   } msrr_job_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] data);
      logic [15:0] c;
      c = crc_in ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[src/msrr_queue.sv]
// two-entry job queue between the frame front end and the reply back end
module msrr_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  msrr_pkg::msrr_job_type push_data,
   input  logic                  pop,
   output logic                  full,
   output logic                  job_valid,
   output msrr_pkg::msrr_job_type job_data
);

   localparam int DEPTH = msrr_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   msrr_pkg::msrr_job_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign job_valid = (count_ff != '0);
   assign job_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && job_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/msrr_front.sv]
// frame front end: collects bytes, checks address and crc, classifies the request
module msrr_front #(
   parameter int NUM_REGS = msrr_pkg::NUM_REGS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  msrr_pkg::msrr_req_type req_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [7:0]             csr_data,
   input  logic                   queue_full,
   output logic                   push_valid,
   output msrr_pkg::msrr_job_type push_data
);

   localparam int HB = msrr_pkg::HDR_BYTES;

   logic [7:0]  slave_addr_ff;
   logic [7:0]  hdr_ff [HB];
   logic [7:0]  hdr_cur [HB];
   logic [15:0] trail_ff;
   logic [15:0] crc_ff, crc_cur;
   logic [7:0]  count_ff, count_in;
   logic [15:0] rx_crc;
   logic        accept, keep;
   logic [8:0]  read_end;
   logic        qty_ok;
   msrr_pkg::msrr_job_kind_type kind;

   assign req_stall = queue_full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      for (int i = 0; i < HB; i++) begin
         hdr_cur[i] = (count_ff == 8'(i)) ? req_data.rx_byte : hdr_ff[i];
      end
   end

   assign count_in = (count_ff == msrr_pkg::COUNT_MAX) ? count_ff : count_ff + 8'd1;
   // crc trails two bytes behind so the received crc stays out of it
   assign crc_cur  = (count_ff >= 8'd2) ? msrr_pkg::crc_feed(crc_ff, trail_ff[15:8]) : crc_ff;
   assign rx_crc   = {req_data.rx_byte, trail_ff[7:0]};
   assign read_end = {1'b0, hdr_cur[3]} + {1'b0, hdr_cur[5]};
   assign qty_ok   = (hdr_cur[4] == 8'h00) && (hdr_cur[5] != 8'h00) &&
                     (hdr_cur[5] <= msrr_pkg::MAX_READ) && (read_end <= 9'(NUM_REGS));

   always_comb begin
      keep = 1'b1;
      kind = msrr_pkg::JOB_EXC_FN;
      priority if (count_in < msrr_pkg::MIN_FRAME_LEN || hdr_cur[0] == 8'h00 ||
                   hdr_cur[0] != slave_addr_ff || rx_crc != crc_cur) begin
         keep = 1'b0;
      end else if (hdr_cur[1] != msrr_pkg::FN_READ && hdr_cur[1] != msrr_pkg::FN_WRITE) begin
         kind = msrr_pkg::JOB_EXC_FN;
      end else if (count_in != msrr_pkg::RW_FRAME_LEN) begin
         keep = 1'b0;
      end else if (hdr_cur[2] != 8'h00) begin
         kind = msrr_pkg::JOB_EXC_ADDR;
      end else if (hdr_cur[1] == msrr_pkg::FN_READ) begin
         priority if (hdr_cur[3] < 8'(NUM_REGS)) begin
            kind = qty_ok ? msrr_pkg::JOB_READ : msrr_pkg::JOB_EXC_ADDR;
         end else if (hdr_cur[3] == 8'(NUM_REGS)) begin
            kind = msrr_pkg::JOB_READ_FLAG;
         end else begin
            kind = msrr_pkg::JOB_EXC_ADDR;
         end
      end else begin
         priority if (hdr_cur[3] < 8'(NUM_REGS)) begin
            kind = msrr_pkg::JOB_WRITE_REG;
         end else if (hdr_cur[3] == 8'(NUM_REGS)) begin
            kind = msrr_pkg::JOB_WRITE_FLAG;
         end else begin
            kind = msrr_pkg::JOB_EXC_ADDR;
         end
      end
   end

   assign push_valid = accept && req_data.frame_end && keep;

   always_comb begin
      push_data.kind = kind;
      for (int i = 0; i < HB; i++) begin
         push_data.hdr[i] = hdr_cur[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff <= msrr_pkg::SLAVE_ADDR_RESET;
         count_ff      <= '0;
         crc_ff        <= msrr_pkg::CRC_INIT;
         trail_ff      <= '0;
      end else begin
         if (csr_valid) begin
            slave_addr_ff <= csr_data;
         end
         if (accept) begin
            if (req_data.frame_end) begin
               count_ff <= '0;
               crc_ff   <= msrr_pkg::CRC_INIT;
               trail_ff <= '0;
            end else begin
               count_ff <= count_in;
               crc_ff   <= crc_cur;
               trail_ff <= {trail_ff[7:0], req_data.rx_byte};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && count_ff < 8'(HB)) begin
         hdr_ff[count_ff[2:0]] <= req_data.rx_byte;
      end
   end

endmodule

[src/msrr_back.sv]
// reply back end: owns registers and flag, builds reply beats with their crc
module msrr_back #(
   parameter int NUM_REGS = msrr_pkg::NUM_REGS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   input  msrr_pkg::msrr_job_type job_data,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output msrr_pkg::msrr_rsp_type rsp_data
);

   localparam int REG_AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

   typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_EMIT} state_type;

   state_type              state_ff;
   msrr_pkg::msrr_job_type job_ff;
   logic [3:0]             idx_ff, len_ff, len_in, body_len;
   logic [15:0]            crc_ff;
   logic                   flag_ff;
   logic                   rsp_valid_ff;
   msrr_pkg::msrr_rsp_type rsp_data_ff;

   logic [7:0]        reg_mem [NUM_REGS];
   logic              reg_valid_ff [NUM_REGS];
   logic [7:0]        rd_data_ff;
   logic              rd_vld_ff;
   logic [7:0]        rd_sum, rd_off;
   logic [REG_AW-1:0] rd_addr, wr_addr;
   logic              rd_in_range, wr_en;

   logic [7:0] reg_byte, beat_byte;
   logic       load_ok, load_beat;

   assign pop       = (state_ff == ST_IDLE) && job_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign load_ok   = !rsp_valid_ff || !rsp_stall;
   assign load_beat = (state_ff == ST_EMIT) && load_ok;
   assign body_len  = len_ff - msrr_pkg::CRC_BYTES;

   // register index for the data beat at idx: start + (idx - 3) / 2
   assign rd_off      = ({4'h0, idx_ff} - 8'd3) >> 1;
   assign rd_sum      = job_ff.hdr[3] + rd_off;
   assign rd_addr     = rd_sum[REG_AW-1:0];
   assign rd_in_range = (rd_sum < 8'(NUM_REGS));

   assign wr_en   = pop && (job_data.kind == msrr_pkg::JOB_WRITE_REG);
   assign wr_addr = job_data.hdr[3][REG_AW-1:0];

   always_comb begin
      unique case (job_data.kind)
         msrr_pkg::JOB_READ:       len_in = msrr_pkg::READ_BASE_LEN +
                                            4'({job_data.hdr[5][2:0], 1'b0});
         msrr_pkg::JOB_READ_FLAG:  len_in = msrr_pkg::FLAG_REPLY_LEN;
         msrr_pkg::JOB_WRITE_REG,
         msrr_pkg::JOB_WRITE_FLAG: len_in = msrr_pkg::WRITE_REPLY_LEN;
         default:                  len_in = msrr_pkg::EXC_REPLY_LEN;
      endcase
   end

   assign reg_byte = rd_vld_ff ? rd_data_ff : 8'h00;

   always_comb begin
      beat_byte = 8'h00;
      priority if (idx_ff == body_len) begin
         beat_byte = crc_ff[7:0];
      end else if (idx_ff > body_len) begin
         beat_byte = crc_ff[15:8];
      end else begin
         unique case (job_ff.kind)
            msrr_pkg::JOB_EXC_FN, msrr_pkg::JOB_EXC_ADDR: begin
               priority if (idx_ff == 4'd0) beat_byte = job_ff.hdr[0];
               else if (idx_ff == 4'd1) beat_byte = job_ff.hdr[1] | msrr_pkg::FN_EXC_FLAG;
               else if (job_ff.kind == msrr_pkg::JOB_EXC_FN) beat_byte = msrr_pkg::EXC_ILLEGAL_FN;
               else beat_byte = msrr_pkg::EXC_ILLEGAL_ADDR;
            end
            msrr_pkg::JOB_READ: begin
               priority if (idx_ff == 4'd0) beat_byte = job_ff.hdr[0];
               else if (idx_ff == 4'd1) beat_byte = msrr_pkg::FN_READ;
               else if (idx_ff == 4'd2) beat_byte = {job_ff.hdr[5][6:0], 1'b0};
               else if (idx_ff[0]) beat_byte = 8'h00;
               else beat_byte = reg_byte;
            end
            msrr_pkg::JOB_READ_FLAG: begin
               priority if (idx_ff == 4'd0) beat_byte = job_ff.hdr[0];
               else if (idx_ff == 4'd1) beat_byte = msrr_pkg::FN_READ;
               else if (idx_ff == 4'd2) beat_byte = msrr_pkg::FLAG_READ_BYTES;
               else if (idx_ff == 4'd3) beat_byte = 8'h00;
               else beat_byte = {7'h00, flag_ff};
            end
            msrr_pkg::JOB_WRITE_REG, msrr_pkg::JOB_WRITE_FLAG: begin
               beat_byte = job_ff.hdr[idx_ff[2:0]];
            end
            default: beat_byte = 8'h00;
         endcase
      end
   end

   // register file with per-entry valid bits, unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (wr_en) begin
         reg_mem[wr_addr] <= job_data.hdr[5];
      end
      rd_data_ff <= reg_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            reg_valid_ff[i] <= 1'b0;
         end
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            reg_valid_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= rd_in_range && reg_valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         len_ff       <= msrr_pkg::EXC_REPLY_LEN;
         crc_ff       <= msrr_pkg::CRC_INIT;
      end else begin
         if (load_beat) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  job_ff <= job_data;
                  idx_ff <= '0;
                  len_ff <= len_in;
                  crc_ff <= msrr_pkg::CRC_INIT;
                  if (job_data.kind == msrr_pkg::JOB_WRITE_FLAG) begin
                     flag_ff <= (job_data.hdr[5] != 8'h00);
                  end
                  state_ff <= ST_ISSUE;
               end
            end
            ST_ISSUE: begin
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (load_ok) begin
                  rsp_data_ff.tx_byte   <= beat_byte;
                  rsp_data_ff.tx_last   <= (idx_ff == len_ff - 4'd1);
                  rsp_data_ff.buzzer_on <= flag_ff;
                  if (idx_ff < body_len) begin
                     crc_ff <= msrr_pkg::crc_feed(crc_ff, beat_byte);
                  end
                  idx_ff   <= idx_ff + 4'd1;
                  state_ff <= (idx_ff == len_ff - 4'd1) ? ST_IDLE : ST_ISSUE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

[src/modbus_slave_register_responder_core.sv]
// top level of the modbus rtu slave register responder core
// modbus rtu slave responder: takes received frame bytes one beat at a time on
// req_, with frame_end set on the last byte of each frame, and answers valid
// frames addressed to it with a reply burst on rsp_ ending in its crc-16 (low
// byte first, tx_last on the final beat). frames with the wrong or broadcast
// address, a bad crc, or a bad length are dropped with no reply. function 3
// reads a run of holding registers or, at index NUM_REGS, the buzzer flag;
// function 6 writes one of them and echoes the request; other functions get
// exception 1, out-of-range addresses or quantities exception 2. received
// bytes are taken whenever req_stall is low; the front end checks the frame
// on its last byte and queues a job in a two-entry queue, and req_stall is
// high only while that queue is full. the idle back end takes a job, then
// builds each reply beat in an issue state (register read) and an emit state
// (output load) that waits on rsp_stall; replies have 5 to 15 beats. the
// slave address is written on csr_ (reset value 1), csr_ready is always high.
// registers reset to zero through per-entry valid bits, no clearing pass
module modbus_slave_register_responder_core #(
   parameter int NUM_REGS = msrr_pkg::NUM_REGS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // received byte beats
   input  logic                   req_valid,
   output logic                   req_stall,
   input  msrr_pkg::msrr_req_type req_data,
   // reply byte beats
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output msrr_pkg::msrr_rsp_type rsp_data,
   // slave address write port
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [7:0]             csr_data
);

   // jobs from the frame checker to the reply builder
   logic                   push_valid;
   msrr_pkg::msrr_job_type push_data;
   logic                   queue_full;
   logic                   job_valid;
   msrr_pkg::msrr_job_type job_data;
   logic                   pop;

   // front end: frame capture, address and crc check, request decode
   msrr_front #(.NUM_REGS(NUM_REGS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   // decouples frame intake from reply output
   msrr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .full       (queue_full),
      .job_valid  (job_valid),
      .job_data   (job_data)
   );

   // back end: register writes, reply beats and reply crc
   msrr_back #(.NUM_REGS(NUM_REGS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_data  (job_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[src/msrr_checker.sv]
// port-level checker for the modbus responder core and its bind
`include "modbus_slave_register_responder_core_defines.svh"

module msrr_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input msrr_pkg::msrr_req_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input msrr_pkg::msrr_rsp_type rsp_data
);

   // a stalled reply beat stays put
   `MSRR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // the job queue only fills on an accepted frame end beat
   `MSRR_ASSERT_IMPL(a_stall_cause, $rose(req_stall), $past(req_valid && !req_stall && req_data.frame_end))

   // reset leaves no reply pending and the intake open
   `MSRR_ASSERT_RESET(a_reset_clear, reset, !rsp_valid && !req_stall)

endmodule

bind modbus_slave_register_responder_core msrr_checker u_msrr_checker (.*);

[tb/modbus_slave_register_responder_core_tb.sv]
// self-checking testbench of the modbus rtu slave register responder core
module modbus_slave_register_responder_core_tb;

   localparam int CLK_PERIOD    = 10;
   localparam int RESET_CYCLES  = 4;
   localparam int NUM_REGS      = msrr_pkg::NUM_REGS_DEFAULT;
   // idle wait long enough to cover a 15-beat reply plus the queue on a busy back end
   localparam int SETTLE_CYCLES = 64;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int PHASE_BEATS   = 30;
   localparam int NUM_ROWS      = 27;

   // how a directed frame is closed
   typedef enum logic [1:0] {
      TRAILER_GOOD,
      TRAILER_BAD,
      TRAILER_NONE
   } trailer_type;

   // one directed frame: body bytes in arrival order, optional filler, then the crc pair;
   // reply_len is the beat count read off by hand (-1 leaves it to the predictor alone)
   typedef struct packed {
      logic [3:0]       body_len;
      logic [0:7][7:0]  body;
      logic [8:0]       fill_len;
      trailer_type      trailer;
      int               reply_len;
      logic [7:0]       reply_b2;
   } frame_row_type;

   // receiver stall patterns, each held for a random stretch
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_SPARSE,
      STALL_DENSE
   } stall_mode_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   msrr_pkg::msrr_req_type req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   msrr_pkg::msrr_rsp_type rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [7:0]             csr_data  = 8'h00;

   // predictor state: station address, frame capture and register file
   logic [7:0]   station_addr;
   logic [7:0]   hdr_bytes [msrr_pkg::HDR_BYTES];
   logic [15:0]  tail_pair;
   logic [15:0]  frame_crc;
   logic [7:0]   frame_len;
   logic [7:0]   hold_regs [NUM_REGS];
   logic         buzzer;

   // reply beats still owed by the block, oldest first
   msrr_pkg::msrr_rsp_type reply_q [$];
   msrr_pkg::msrr_rsp_type reply_want;
   logic [7:0]   reply_msg [$];
   logic [7:0]   frame_bytes [$];
   int           last_reply_len;
   logic [7:0]   last_reply_b2;

   frame_row_type directed_rows [NUM_ROWS];

   int fail_count       = 0;
   int frames_sent      = 0;
   int beats_sent       = 0;
   int beats_checked    = 0;
   int replies_expected = 0;
   int burst_left       = 0;

   stall_mode_type stall_mode   = STALL_NONE;
   int             stall_hold   = 0;
   int             stall_phase  = 0;
   int             stall_period = 4;

   modbus_slave_register_responder_core #(
      .NUM_REGS(NUM_REGS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // modbus crc-16, reflected, one byte at a time
   function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] data);
      logic [15:0] r;
      int          n;
      r = {acc[15:8], acc[7:0] ^ data};
      for (n = 0; n < 8; n++) r = (r >> 1) ^ (r[0] ? msrr_pkg::CRC_POLY : 16'h0000);
      return r;
   endfunction

   // frame capture goes back to its idle values
   task automatic clear_frame();
      int k;
      for (k = 0; k < msrr_pkg::HDR_BYTES; k++) hdr_bytes[k] = 8'h00;
      tail_pair = 16'h0000;
      frame_crc = msrr_pkg::CRC_INIT;
      frame_len = 8'h00;
   endtask

   // closes reply_msg with its crc and queues one beat per byte
   task automatic queue_reply();
      logic [15:0]            c;
      msrr_pkg::msrr_rsp_type beat;
      int                     k;
      c = msrr_pkg::CRC_INIT;
      for (k = 0; k < reply_msg.size(); k++) c = crc16_step(c, reply_msg[k]);
      reply_msg.push_back(c[7:0]);
      reply_msg.push_back(c[15:8]);
      last_reply_len = reply_msg.size();
      last_reply_b2  = reply_msg[2];
      for (k = 0; k < reply_msg.size(); k++) begin
         beat.tx_byte   = reply_msg[k];
         beat.tx_last   = (k == reply_msg.size() - 1);
         beat.buzzer_on = buzzer;
         reply_q.push_back(beat);
      end
      replies_expected++;
   endtask

   task automatic queue_exception(input logic [7:0] code);
      reply_msg.delete();
      reply_msg.push_back(hdr_bytes[0]);
      reply_msg.push_back(hdr_bytes[1] | msrr_pkg::FN_EXC_FLAG);
      reply_msg.push_back(code);
      queue_reply();
   endtask

   // decision taken on the last byte of a frame
   task automatic decode_frame();
      logic [15:0] sent_crc;
      int          first;
      int          count;
      int          k;
      last_reply_len = 0;
      // too short, not for this station, or corrupted: silently dropped
      if (frame_len < msrr_pkg::MIN_FRAME_LEN) return;
      if (hdr_bytes[0] == 8'h00 || hdr_bytes[0] != station_addr) return;
      sent_crc = {tail_pair[7:0], tail_pair[15:8]};
      if (sent_crc != frame_crc) return;
      if (hdr_bytes[1] != msrr_pkg::FN_READ && hdr_bytes[1] != msrr_pkg::FN_WRITE) begin
         queue_exception(msrr_pkg::EXC_ILLEGAL_FN);
         return;
      end
      // read and write requests have exactly one legal length
      if (frame_len != msrr_pkg::RW_FRAME_LEN) return;
      first = {hdr_bytes[2], hdr_bytes[3]};
      count = {hdr_bytes[4], hdr_bytes[5]};
      reply_msg.delete();
      if (hdr_bytes[1] == msrr_pkg::FN_READ) begin
         if (first < NUM_REGS) begin
            if (count < 1 || count > msrr_pkg::MAX_READ || first + count > NUM_REGS) begin
               queue_exception(msrr_pkg::EXC_ILLEGAL_ADDR);
            end else begin
               reply_msg.push_back(hdr_bytes[0]);
               reply_msg.push_back(msrr_pkg::FN_READ);
               reply_msg.push_back(8'(2 * count));
               for (k = 0; k < count; k++) begin
                  reply_msg.push_back(8'h00);
                  reply_msg.push_back(hold_regs[first + k]);
               end
               queue_reply();
            end
         end else if (first == NUM_REGS) begin
            // buzzer flag sits right after the registers, quantity ignored
            reply_msg.push_back(hdr_bytes[0]);
            reply_msg.push_back(msrr_pkg::FN_READ);
            reply_msg.push_back(msrr_pkg::FLAG_READ_BYTES);
            reply_msg.push_back(8'h00);
            reply_msg.push_back({7'b0, buzzer});
            queue_reply();
         end else begin
            queue_exception(msrr_pkg::EXC_ILLEGAL_ADDR);
         end
      end else begin
         if (first < NUM_REGS) begin
            hold_regs[first] = hdr_bytes[5];
         end else if (first == NUM_REGS) begin
            buzzer = (hdr_bytes[5] != 8'h00);
         end else begin
            queue_exception(msrr_pkg::EXC_ILLEGAL_ADDR);
            return;
         end
         // write reply echoes the request header
         for (k = 0; k < msrr_pkg::HDR_BYTES; k++) reply_msg.push_back(hdr_bytes[k]);
         queue_reply();
      end
   endtask

   // one accepted byte through the predictor
   task automatic model_rx_byte(input logic [7:0] b, input logic last);
      if (frame_len < msrr_pkg::HDR_BYTES) hdr_bytes[frame_len] = b;
      // crc runs two bytes behind, so the trailer itself is never folded in
      if (frame_len >= 2) frame_crc = crc16_step(frame_crc, tail_pair[15:8]);
      tail_pair = {tail_pair[7:0], b};
      if (frame_len != msrr_pkg::COUNT_MAX) frame_len++;
      if (last) begin
         decode_frame();
         clear_frame();
      end
   endtask

   // offers one beat, waits for it to be taken, then maybe idles between bursts
   task automatic send_beat(input logic [7:0] b, input logic last);
      int gap;
      req_valid <= 1'b1;
      req_data  <= '{rx_byte: b, frame_end: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      model_rx_byte(b, last);
      beats_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 40);
         case ($urandom_range(0, 7))
            0, 1:    gap = 0;
            2:       gap = $urandom_range(20, 60);
            default: gap = $urandom_range(1, 8);
         endcase
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_frame();
      int k;
      for (k = 0; k < frame_bytes.size(); k++) begin
         send_beat(frame_bytes[k], k == frame_bytes.size() - 1);
      end
      frames_sent++;
   endtask

   task automatic add_crc();
      logic [15:0] c;
      int          k;
      c = msrr_pkg::CRC_INIT;
      for (k = 0; k < frame_bytes.size(); k++) c = crc16_step(c, frame_bytes[k]);
      frame_bytes.push_back(c[7:0]);
      frame_bytes.push_back(c[15:8]);
   endtask

   task automatic put_request(input logic [7:0] addr, input logic [7:0] fn,
                              input logic [15:0] first, input logic [15:0] count);
      frame_bytes.push_back(addr);
      frame_bytes.push_back(fn);
      frame_bytes.push_back(first[15:8]);
      frame_bytes.push_back(first[7:0]);
      frame_bytes.push_back(count[15:8]);
      frame_bytes.push_back(count[7:0]);
   endtask

   // sender holds off until every owed reply beat has come back
   task automatic wait_replies_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (reply_q.size() != 0) @(posedge clock);
   endtask

   // station address changes only with the block idle
   task automatic set_station(input logic [7:0] addr);
      wait_replies_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= addr;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid    <= 1'b0;
      station_addr = addr;
   endtask

   // mostly well-formed requests with random content, the rest broken or noise
   task automatic send_random_frame();
      int          kind;
      int          first;
      int          n;
      int          k;
      logic [15:0] count;
      logic [7:0]  addr;
      logic [7:0]  fn;
      frame_bytes.delete();
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
         // good read, now and then of the buzzer flag with any quantity
         if ($urandom_range(0, 5) == 0) begin
            put_request(station_addr, msrr_pkg::FN_READ, 16'(NUM_REGS), 16'($urandom));
         end else begin
            first = $urandom_range(0, NUM_REGS - 1);
            put_request(station_addr, msrr_pkg::FN_READ, 16'(first),
                        16'($urandom_range(1, NUM_REGS - first)));
         end
         add_crc();
      end else if (kind < 65) begin
         // good write of a register or the flag
         count = 16'($urandom);
         if ($urandom_range(0, 3) == 0) count[7:0] = 8'h00;
         put_request(station_addr, msrr_pkg::FN_WRITE,
                     16'($urandom_range(0, NUM_REGS)), count);
         add_crc();
      end else if (kind < 75) begin
         // well-framed but likely out of range or unsupported
         fn = ($urandom_range(0, 2) == 0) ? 8'($urandom) :
              ($urandom_range(0, 1) ? msrr_pkg::FN_READ : msrr_pkg::FN_WRITE);
         case ($urandom_range(0, 2))
            0:       first = $urandom_range(0, 8);
            1:       first = {8'($urandom_range(1, 255)), 8'($urandom)};
            default: first = $urandom_range(0, 65535);
         endcase
         count = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 8)) : 16'($urandom);
         put_request(station_addr, fn, 16'(first), count);
         add_crc();
      end else if (kind < 83) begin
         // broadcast or another station
         addr = ($urandom_range(0, 1) == 0) ? 8'h00 :
                8'(station_addr + 8'($urandom_range(1, 255)));
         put_request(addr, $urandom_range(0, 1) ? msrr_pkg::FN_READ : msrr_pkg::FN_WRITE,
                     16'($urandom_range(0, NUM_REGS)), 16'($urandom_range(1, 2)));
         add_crc();
      end else if (kind < 88) begin
         // one flipped bit in the crc pair
         put_request(station_addr, msrr_pkg::FN_READ, 16'h0000, 16'(NUM_REGS));
         add_crc();
         k = frame_bytes.size() - 1 - $urandom_range(0, 1);
         frame_bytes[k] = frame_bytes[k] ^ 8'(1 << $urandom_range(0, 7));
      end else begin
         // noise of random length, sometimes aimed at this station with a good crc
         n = $urandom_range(1, 12);
         for (k = 0; k < n; k++) frame_bytes.push_back(8'($urandom));
         if ($urandom_range(0, 1) == 0) frame_bytes[0] = station_addr;
         if ($urandom_range(0, 1) == 0) add_crc();
      end
      send_frame();
   endtask

   // receiver back-pressure: a pattern picked at random and held for a while
   always @(posedge clock) begin
      if (stall_hold == 0) begin
         stall_mode   = stall_mode_type'($urandom_range(0, 3));
         stall_period = $urandom_range(2, 9);
         stall_hold   = $urandom_range(16, 160);
      end else begin
         stall_hold = stall_hold - 1;
      end
      stall_phase = (stall_phase + 1) % stall_period;
      case (stall_mode)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_RANDOM: rsp_stall <= ($urandom_range(0, 99) < 35);
         STALL_SPARSE: rsp_stall <= (stall_phase == 0);
         default:      rsp_stall <= (stall_phase != 0);
      endcase
   end

   // every reply beat taken is matched against the oldest owed beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (reply_q.size() == 0) begin
            $error("reply beat %02h arrived with nothing owed", rsp_data.tx_byte);
            fail_count++;
         end else begin
            reply_want = reply_q.pop_front();
            beats_checked++;
            if (rsp_data.tx_byte !== reply_want.tx_byte) begin
               $error("tx_byte expected %02h got %02h", reply_want.tx_byte, rsp_data.tx_byte);
               fail_count++;
            end
            if (rsp_data.tx_last !== reply_want.tx_last) begin
               $error("tx_last expected %0b got %0b", reply_want.tx_last, rsp_data.tx_last);
               fail_count++;
            end
            if (rsp_data.buzzer_on !== reply_want.buzzer_on) begin
               $error("buzzer_on expected %0b got %0b", reply_want.buzzer_on,
                      rsp_data.buzzer_on);
               fail_count++;
            end
         end
      end
   end

   initial begin : stimulus
      frame_row_type row;
      logic [7:0]    third_addr;
      int            r;
      int            k;
      int            phase;
      int            phase_start;

      directed_rows = '{
         // reads straight after reset see zeros
         '{6, 64'h01_03_00_00_00_01_00_00, 0,   TRAILER_GOOD, 7,  8'h02},
         '{6, 64'h01_03_00_00_00_05_00_00, 0,   TRAILER_GOOD, 15, 8'h0A},
         // writes, value high byte ignored
         '{6, 64'h01_06_00_00_00_FF_00_00, 0,   TRAILER_GOOD, 8,  8'h00},
         '{6, 64'h01_06_00_04_A5_5A_00_00, 0,   TRAILER_GOOD, 8,  8'h00},
         '{6, 64'h01_06_00_02_FF_00_00_00, 0,   TRAILER_GOOD, 8,  8'h00},
         '{6, 64'h01_03_00_00_00_05_00_00, 0,   TRAILER_GOOD, -1, 8'h00},
         // buzzer flag: read ignores quantity, write tests only the low byte
         '{6, 64'h01_03_00_05_FF_FF_00_00, 0,   TRAILER_GOOD, 7,  8'h02},
         '{6, 64'h01_06_00_05_01_00_00_00, 0,   TRAILER_GOOD, 8,  8'h00},
         '{6, 64'h01_06_00_05_00_80_00_00, 0,   TRAILER_GOOD, -1, 8'h00},
         '{6, 64'h01_03_00_05_00_00_00_00, 0,   TRAILER_GOOD, -1, 8'h00},
         // unsupported functions, any length from four bytes up
         '{6, 64'h01_10_00_00_00_01_00_00, 0,   TRAILER_GOOD, 5,  8'h01},
         '{2, 64'h01_2B_00_00_00_00_00_00, 0,   TRAILER_GOOD, 5,  8'h01},
         '{4, 64'h01_FF_00_00_00_00_00_00, 0,   TRAILER_GOOD, 5,  8'h01},
         // byte count saturates on an overlong frame
         '{2, 64'h01_41_00_00_00_00_00_00, 252, TRAILER_GOOD, 5,  8'h01},
         // illegal data address on reads and writes
         '{6, 64'h01_03_00_00_00_00_00_00, 0,   TRAILER_GOOD, 5,  8'h02},
         '{6, 64'h01_03_00_00_00_06_00_00, 0,   TRAILER_GOOD, 5,  8'h02},
         '{6, 64'h01_03_00_03_00_03_00_00, 0,   TRAILER_GOOD, 5,  8'h02},
         '{6, 64'h01_03_00_00_01_01_00_00, 0,   TRAILER_GOOD, 5,  8'h02},
         '{6, 64'h01_03_FF_00_00_01_00_00, 0,   TRAILER_GOOD, 5,  8'h02},
         '{6, 64'h01_03_00_06_00_01_00_00, 0,   TRAILER_GOOD, 5,  8'h02},
         '{6, 64'h01_06_00_06_00_01_00_00, 0,   TRAILER_GOOD, 5,  8'h02},
         '{6, 64'h01_06_80_00_00_01_00_00, 0,   TRAILER_GOOD, 5,  8'h02},
         // dropped: other station, broadcast, bad crc, short, wrong length
         '{6, 64'h02_03_00_00_00_01_00_00, 0,   TRAILER_GOOD, 0,  8'h00},
         '{6, 64'h00_06_00_00_00_01_00_00, 0,   TRAILER_GOOD, 0,  8'h00},
         '{6, 64'h01_03_00_00_00_01_00_00, 0,   TRAILER_BAD,  0,  8'h00},
         '{3, 64'h01_03_00_00_00_00_00_00, 0,   TRAILER_NONE, 0,  8'h00},
         '{7, 64'h01_03_00_00_00_01_00_00, 0,   TRAILER_GOOD, 0,  8'h00}
      };

      // predictor reset state
      station_addr = msrr_pkg::SLAVE_ADDR_RESET;
      for (k = 0; k < NUM_REGS; k++) hold_regs[k] = 8'h00;
      buzzer = 1'b0;
      clear_frame();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames against the reset station address
      for (r = 0; r < NUM_ROWS; r++) begin
         row = directed_rows[r];
         frame_bytes.delete();
         for (k = 0; k < row.body_len; k++) frame_bytes.push_back(row.body[k]);
         for (k = 0; k < row.fill_len; k++) frame_bytes.push_back(8'($urandom));
         if (row.trailer != TRAILER_NONE) add_crc();
         if (row.trailer == TRAILER_BAD) begin
            frame_bytes[frame_bytes.size() - 1] = frame_bytes[frame_bytes.size() - 1] ^ 8'h01;
         end
         send_frame();
         if (row.reply_len >= 0 && last_reply_len != row.reply_len) begin
            $error("row %0d: reply length expected %0d got %0d", r, row.reply_len,
                   last_reply_len);
            fail_count++;
         end
         if (row.reply_len > 0 && last_reply_b2 != row.reply_b2) begin
            $error("row %0d: third reply byte expected %02h got %02h", r, row.reply_b2,
                   last_reply_b2);
            fail_count++;
         end
      end

      // random phases: highest station address, a random one, then back to the lowest
      third_addr = 8'($urandom_range(2, 246));
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       set_station(8'd247);
            1:       set_station(third_addr);
            default: set_station(8'd1);
         endcase
         phase_start = beats_sent;
         while (beats_sent - phase_start < PHASE_BEATS) begin
            send_random_frame();
            // now and then let the block run completely dry
            if ($urandom_range(0, 11) == 0) wait_replies_drained();
         end
      end

      wait_replies_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d frames in %0d byte beats, %0d replies with %0d beats checked",
               frames_sent, beats_sent, replies_expected, beats_checked);
      $display("station addresses 1, 247 and %0d, registers, flag, exceptions and drops",
               third_addr);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // hard stop in case the block hangs
   initial begin
      #(LIMIT_CYCLES * CLK_PERIOD);
      $display("TEST FAILED");
      $finish;
   end

endmodule

[modbus_slave_register_responder_core.f]
+incdir+src
src/msrr_pkg.sv
src/msrr_queue.sv
src/msrr_front.sv
src/msrr_back.sv
src/modbus_slave_register_responder_core.sv
src/msrr_checker.sv
tb/modbus_slave_register_responder_core_tb.sv
